### src/bui_pkg.sv
`timescale 1ns / 1ps
// bui_pkg: shared types, constants and codes of the bilinear upscaler
// no dependencies; used by every module of the block

package bui_pkg;

    // default parameter values for the top level
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_SCALE      = 4;

    // field widths fixed by the item formats
    localparam int PIX_W     = 8;
    localparam int COORD_W   = 10;
    localparam int SRC_W     = 8;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    // widths that cover the whole parameter range (MAX_* up to 4096, SCALE up to 8)
    localparam int IDX_W  = 12;   // source column or row index
    localparam int U_W    = 12;   // 2*d + 1 + SCALE for a 10-bit d
    localparam int FRAC_W = 4;    // fraction in units of 1/(2*SCALE)
    localparam int WT_W   = 9;    // product of two axis weights, up to 256
    localparam int ACC_W  = 17;   // weighted sum plus rounding term

    localparam logic [PIX_W-1:0] PIX_MAX   = 8'd255;
    localparam logic [CFG_W-1:0] SIZE_RST  = 9'd256;

    // item operation codes
    localparam logic FUNC_STORE   = 1'b0;
    localparam logic FUNC_COMPUTE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT = 1'b1;

    // queue between front and back
    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic               func;
        logic [SRC_W-1:0]   src_col;
        logic [SRC_W-1:0]   src_row;
        logic [PIX_W-1:0]   pixel_in;
        logic [COORD_W-1:0] dst_col;
        logic [COORD_W-1:0] dst_row;
    } req_item_t;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_out;
        logic [COORD_W-1:0] out_col;
        logic [COORD_W-1:0] out_row;
        logic               out_of_range;
    } rsp_item_t;

    // classified work handed from front to back
    // store: xs[0], ys[0] and pixel; compute: neighbours, weights and echo
    typedef struct packed {
        logic                       is_store;
        logic                       oor;
        logic [1:0][IDX_W-1:0]      xs;
        logic [1:0][IDX_W-1:0]      ys;
        logic [3:0][WT_W-1:0]       wt;
        logic [PIX_W-1:0]           pixel;
        logic [COORD_W-1:0]         col;
        logic [COORD_W-1:0]         row;
    } job_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_FETCH,
        B_LAST,
        B_SEND
    } back_state_t;

endpackage

### src/bilinear_upscale_inverted.sv
`timescale 1ns / 1ps
// bilinear_upscale_inverted: top level of the integer-factor bilinear upscaler
// depends on bui_pkg, bui_front, bui_queue, bui_back
//
//   req channel (req_valid / req_stall / req_data) takes one item per handshake:
//   func 0 writes pixel_in at (src_col, src_row) of the frame store and gives no
//   result; func 1 asks for destination pixel (dst_col, dst_row) and gives one
//   item on the rsp channel: 255 minus the bilinear value, coordinates echoed,
//   out_of_range set (and 255 returned) beyond source size times SCALE
//   cfg port: cfg_write with cfg_index 0 (image width) or 1 (image height)
//   timing
//   - the front classifies an item in its accept cycle and pushes a job into a
//     two-entry queue; req_stall is high only while that queue is full
//   - the back pops each job in its idle state and writes a store job there; an
//     out-of-range job goes from idle to send, and an in-range job goes from
//     idle through fetch, where the read port of the frame store makes four reads
//     (one neighbour each), then last (last accumulate) and send (result load)
//   - the back takes no new job until the current one has loaded its result
//   reset: queue and back control clear, sizes return to 256; the frame store
//   keeps no reset and must be written before it is read; rsp_stall holds the
//   result register and the queue keeps accepting until full

module bilinear_upscale_inverted
    import bui_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int SCALE      = DEF_SCALE
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_item_t            req_data,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_item_t            rsp_data
);

    // front to queue
    logic q_push;
    job_t q_job;
    logic q_full;

    // queue to back
    logic q_pop;
    logic q_valid;
    job_t q_head;

    // classification and size registers
    bui_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .SCALE      (SCALE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    // decouples acceptance from the multi-cycle back end
    bui_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_head)
    );

    // frame store, neighbour fetch and result register
    bui_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .SCALE      (SCALE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

### src/bui_front.sv
`timescale 1ns / 1ps
// bui_front: size registers, item acceptance and classification into jobs
// depends on bui_pkg

module bui_front
    import bui_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int SCALE      = DEF_SCALE
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_item_t            req_data,
    input  logic                 q_full,
    output logic                 q_push,
    output job_t                 q_job
);

    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int SW      = $clog2(MAX_DIM + 1);
    localparam int RW      = (CFG_W > SW) ? CFG_W : SW;
    localparam int UNIT    = 2 * SCALE;
    localparam int FR_SH   = $clog2(UNIT);
    localparam int SC_SH   = $clog2(SCALE);
    localparam int LW      = SW + SC_SH;
    localparam int CW      = (LW > COORD_W) ? LW : COORD_W;
    localparam int AXW     = (U_W > SW) ? U_W : SW;
    localparam int WX_W    = FRAC_W + 1;
    localparam int SCW     = (SRC_W > IDX_W) ? SRC_W : IDX_W;
    localparam int MW      = (SCW > 32) ? SCW : 32;

    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;

    logic [SW-1:0]     w_eff, h_eff;
    logic [LW-1:0]     lim_x, lim_y;
    logic [U_W-1:0]    ux, uy;
    logic [FRAC_W-1:0] fx, fy;
    logic [WX_W-1:0]   wx0, wx1, wy0, wy1;
    logic [2*IDX_W-1:0] ax, ay;
    logic              accept;
    logic              store_ok;

    // a size of zero acts as one, above the store limit acts as the limit
    function automatic logic [SW-1:0] clamp_size(input logic [CFG_W-1:0] raw,
                                                 input logic [SW-1:0] lim);
        logic [SW-1:0] res;
        if (raw == '0)
            res = SW'(1);
        else if (RW'(raw) > RW'(lim))
            res = lim;
        else
            res = SW'(raw);
        return res;
    endfunction

    // lower and upper neighbour: lower from unclamped floor, both kept in the image
    function automatic logic [2*IDX_W-1:0] axis_pair(input logic [U_W-1:0] u,
                                                     input logic [SW-1:0] size);
        logic [AXW-1:0] whole;
        logic [AXW-1:0] top;
        logic [AXW-1:0] lo;
        logic [AXW-1:0] hi;
        whole = AXW'(u >> FR_SH);
        top   = AXW'(size) - AXW'(1);
        lo    = (whole == '0) ? '0 : whole - AXW'(1);
        if (lo > top)
            lo = top;
        hi = (lo + AXW'(1) > top) ? top : lo + AXW'(1);
        return {IDX_W'(hi), IDX_W'(lo)};
    endfunction

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMG_WIDTH:  width_next  = cfg_data;
                REG_IMG_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_RST;
            height_reg <= SIZE_RST;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    always_comb
    begin
        w_eff = clamp_size(width_reg, SW'(MAX_WIDTH));
        h_eff = clamp_size(height_reg, SW'(MAX_HEIGHT));
        lim_x = LW'(w_eff) << SC_SH;
        lim_y = LW'(h_eff) << SC_SH;

        // source position plus one, in units of 1/(2*SCALE)
        ux = U_W'({req_data.dst_col, 1'b1}) + U_W'(SCALE);
        uy = U_W'({req_data.dst_row, 1'b1}) + U_W'(SCALE);
        fx = FRAC_W'(ux & U_W'(UNIT - 1));
        fy = FRAC_W'(uy & U_W'(UNIT - 1));
        wx1 = WX_W'(fx);
        wy1 = WX_W'(fy);
        wx0 = WX_W'(UNIT) - wx1;
        wy0 = WX_W'(UNIT) - wy1;
        ax  = axis_pair(ux, w_eff);
        ay  = axis_pair(uy, h_eff);

        q_job          = '0;
        q_job.is_store = (req_data.func == FUNC_STORE);
        q_job.pixel    = req_data.pixel_in;
        q_job.col      = req_data.dst_col;
        q_job.row      = req_data.dst_row;
        q_job.oor      = (CW'(req_data.dst_col) >= CW'(lim_x))
                      || (CW'(req_data.dst_row) >= CW'(lim_y));
        if (req_data.func == FUNC_STORE)
        begin
            q_job.xs[0] = IDX_W'(req_data.src_col);
            q_job.ys[0] = IDX_W'(req_data.src_row);
        end
        else
        begin
            q_job.xs[0] = ax[IDX_W-1:0];
            q_job.xs[1] = ax[2*IDX_W-1:IDX_W];
            q_job.ys[0] = ay[IDX_W-1:0];
            q_job.ys[1] = ay[2*IDX_W-1:IDX_W];
        end
        // neighbour order: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
        q_job.wt[0] = WT_W'(wx0) * WT_W'(wy0);
        q_job.wt[1] = WT_W'(wx1) * WT_W'(wy0);
        q_job.wt[2] = WT_W'(wx0) * WT_W'(wy1);
        q_job.wt[3] = WT_W'(wx1) * WT_W'(wy1);

        // stores beyond the frame store are dropped
        store_ok = (MW'(req_data.src_col) < MW'(MAX_WIDTH))
                && (MW'(req_data.src_row) < MW'(MAX_HEIGHT));
        req_stall = q_full;
        accept    = req_valid && !q_full;
        q_push    = accept && ((req_data.func == FUNC_COMPUTE) || store_ok);
    end

endmodule

### src/bui_queue.sv
`timescale 1ns / 1ps
// bui_queue: short job fifo between front and back
// depends on bui_pkg

module bui_queue
    import bui_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    localparam int Q_PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW = $clog2(Q_DEPTH + 1);

    job_t            slot_reg [Q_DEPTH];
    logic [Q_PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    function automatic logic [Q_PW-1:0] bump(input logic [Q_PW-1:0] p);
        return (p == Q_PW'(Q_DEPTH - 1)) ? '0 : p + Q_PW'(1);
    endfunction

    always_comb
    begin
        full       = (count_reg == Q_CW'(Q_DEPTH));
        head_valid = (count_reg != '0);
        head_job   = slot_reg[rd_ptr_reg];
        do_push    = push && !full;
        do_pop     = pop && head_valid;
        wr_ptr_next = do_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + Q_CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - Q_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

### src/bui_back.sv
`timescale 1ns / 1ps
// bui_back: frame store, neighbour fetch, weighted sum and result register
// depends on bui_pkg

module bui_back
    import bui_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int SCALE      = DEF_SCALE
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  job_t      q_head,
    output logic      q_pop,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int UNIT  = 2 * SCALE;
    localparam int SH2   = 2 * $clog2(UNIT);
    localparam int RND   = (UNIT * UNIT) / 2;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    back_state_t      state_reg, state_next;
    job_t             job_reg, job_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_item_t        rsp_reg, rsp_next;

    logic             mem_we;
    logic [AW-1:0]    wr_addr;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [1:0]       acc_idx;
    logic [ACC_W-1:0] rounded;
    logic [ACC_W-1:0] val_wide;
    logic [PIX_W-1:0] val;

    function automatic logic [AW-1:0] pix_addr(input logic [IDX_W-1:0] col,
                                               input logic [IDX_W-1:0] row);
        return AW'(AW'(row) * AW'(MAX_WIDTH)) + AW'(col);
    endfunction

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        wr_addr        = pix_addr(q_head.xs[0], q_head.ys[0]);
        rd_en          = 1'b0;
        rd_addr        = pix_addr(job_reg.xs[cnt_reg[0]], job_reg.ys[cnt_reg[1]]);
        acc_idx        = cnt_reg - 2'd1;

        // round half up, then invert
        rounded  = acc_reg + ACC_W'(RND);
        val_wide = rounded >> SH2;
        val      = (val_wide > ACC_W'(PIX_MAX)) ? PIX_MAX : val_wide[PIX_W-1:0];

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    job_next = q_head;
                    cnt_next = 2'd0;
                    acc_next = '0;
                    if (q_head.is_store)
                        mem_we = 1'b1;
                    else if (q_head.oor)
                        state_next = B_SEND;
                    else
                        state_next = B_FETCH;
                end
            end
            B_FETCH:
            begin
                rd_en = 1'b1;
                if (cnt_reg != 2'd0)
                    acc_next = acc_reg + ACC_W'(job_reg.wt[acc_idx]) * ACC_W'(rd_data_reg);
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    state_next = B_LAST;
            end
            B_LAST:
            begin
                acc_next   = acc_reg + ACC_W'(job_reg.wt[acc_idx]) * ACC_W'(rd_data_reg);
                state_next = B_SEND;
            end
            B_SEND:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.out_col      = job_reg.col;
                    rsp_next.out_row      = job_reg.row;
                    rsp_next.out_of_range = job_reg.oor;
                    rsp_next.pixel_out    = job_reg.oor ? PIX_MAX : PIX_MAX - val;
                    state_next            = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= 2'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        acc_reg <= acc_next;
        rsp_reg <= rsp_next;
    end

    // frame store: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= q_head.pixel;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule
